/* design/dpi_pkg.sv */
// Shared types, constants, tables and helpers for the damped pendulum integrator.
`default_nettype none

package dpi_pkg;

  // state and arithmetic widths
  localparam int STATE_WIDTH        = 16;
  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int MAW = STATE_WIDTH + 6;   // multiplier operand A, signed
  localparam int MBW = 18;                // multiplier operand B, signed
  localparam int PW  = MAW + MBW;         // product and accumulate width
  localparam int DTW = 15;                // dt in Q0.16, at most 16711
  localparam int SVW = 15;                // sine magnitude, Q2.14, 0..16384
  localparam int TIW = $clog2(SINE_TABLE_ENTRIES + 1);

  // commands
  localparam logic [1:0] CMD_FREE    = 2'd0;
  localparam logic [1:0] CMD_RESET   = 2'd1;
  localparam logic [1:0] CMD_DRAG    = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  // register indexes
  localparam logic [1:0] REG_OMEGA_SQ    = 2'd0;
  localparam logic [1:0] REG_DAMPING     = 2'd1;
  localparam logic [1:0] REG_START_ANGLE = 2'd2;
  localparam logic [1:0] REG_MAX_STEP_MS = 2'd3;

  // register reset values
  localparam logic [15:0] OMEGA_SQ_RESET    = 16'd27853;
  localparam logic [15:0] DAMPING_RESET     = 16'd614;
  localparam logic [15:0] START_ANGLE_RESET = 16'd3217;
  localparam logic [7:0]  MAX_STEP_MS_RESET = 8'd50;

  // 1/(2*pi) turns per radian, Q12 times 2^16 turn units
  localparam logic [MBW-1:0] TURN_PER_RAD = 18'd10430;
  localparam logic [63:0]    HALF_PI_Q30  = 64'd1686629713;

  typedef logic [SVW-1:0] sine_tab_t [0:SINE_TABLE_ENTRIES];
  typedef logic [DTW-1:0] dt_tab_t [0:255];

  typedef struct packed {
    logic [15:0] omega_sq;
    logic [15:0] damping_rate;
    logic [15:0] start_angle;
    logic [7:0]  max_step_ms;
  } cfg_t;

  typedef struct packed {
    logic                          load_theta;
    logic                          zero_omega;
    logic                          do_step;
    logic signed [STATE_WIDTH-1:0] theta_val;
    logic [DTW-1:0]                dt;
  } op_t;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(PW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    lo = {{(PW-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
    if (v > hi) begin
      return hi[STATE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[STATE_WIDTH-1:0];
    end
    return v[STATE_WIDTH-1:0];
  endfunction

  function automatic logic signed [STATE_WIDTH-1:0] clamp_in(input logic signed [15:0] v);
    logic signed [PW-1:0] w;
    w = PW'(v);
    return sat_state(w);
  endfunction

  // quarter-wave sine, Q2.14, Taylor series in Q30
  function automatic sine_tab_t build_sine();
    sine_tab_t         tab;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 64'sd32768) >>> 16;
      if (r > 64'sd16384) begin
        r = 64'sd16384;
      end
      tab[i] = r[SVW-1:0];
    end
    return tab;
  endfunction

  // milliseconds to seconds, Q0.16, floor
  function automatic dt_tab_t build_dt();
    dt_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = DTW'((i * 65536) / 1000);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine();
  localparam dt_tab_t   DT_TABLE   = build_dt();

endpackage

`default_nettype wire

/* design/dpi_front.sv */
// Front end: accepts ticks, clamps time, classifies the command into an op.
`default_nettype none

module dpi_front (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          command,
  input  wire logic [15:0]         elapsed_ms,
  input  wire logic signed [15:0]  drag_angle,
  input  wire dpi_pkg::cfg_t       cfg,
  input  wire logic                queue_full,
  output logic                     push,
  output dpi_pkg::op_t             op
);

  logic [7:0] ms;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    ms = (elapsed_ms < {8'd0, cfg.max_step_ms}) ? elapsed_ms[7:0] : cfg.max_step_ms;
    op.dt = dpi_pkg::DT_TABLE[ms];
    if (command == dpi_pkg::CMD_RESET) begin
      op.theta_val = dpi_pkg::clamp_in($signed(cfg.start_angle));
    end else begin
      op.theta_val = dpi_pkg::clamp_in(drag_angle);
    end
    unique case (command)
      dpi_pkg::CMD_FREE: begin
        op.load_theta = 1'b0;
        op.zero_omega = 1'b0;
        op.do_step    = 1'b1;
      end
      dpi_pkg::CMD_RESET: begin
        op.load_theta = 1'b1;
        op.zero_omega = 1'b1;
        op.do_step    = 1'b1;
      end
      dpi_pkg::CMD_DRAG: begin
        op.load_theta = 1'b1;
        op.zero_omega = 1'b1;
        op.do_step    = 1'b0;
      end
      dpi_pkg::CMD_RELEASE: begin
        op.load_theta = 1'b0;
        op.zero_omega = 1'b1;
        op.do_step    = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/dpi_queue.sv */
// Two-entry op queue between front end and sequencer.
`default_nettype none

module dpi_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire dpi_pkg::op_t  wr_op,
  input  wire logic          pop,
  output dpi_pkg::op_t       rd_op,
  output logic               full,
  output logic               empty
);

  dpi_pkg::op_t slots [0:1];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_op;
  end

  assign rd_op = slots[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

`default_nettype wire

/* design/dpi_back.sv */
// Back end: state registers, step sequencer with one shared multiplier, result register.
`default_nettype none

module dpi_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dpi_pkg::op_t        op,
  input  wire logic                queue_empty,
  output logic                     pop,
  input  wire dpi_pkg::cfg_t       cfg,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       angle,
  output logic signed [15:0]       rate
);

  localparam int SW  = dpi_pkg::STATE_WIDTH;
  localparam int MAW = dpi_pkg::MAW;
  localparam int MBW = dpi_pkg::MBW;
  localparam int PW  = dpi_pkg::PW;
  localparam int TIW = dpi_pkg::TIW;
  localparam int IXW = 14 + TIW;
  localparam int DTW = dpi_pkg::DTW;
  localparam int SVW = dpi_pkg::SVW;

  localparam logic signed [PW-1:0] RND14 = PW'(8192);
  localparam logic signed [PW-1:0] RND16 = PW'(32768);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PHASE = 4'd1;
  localparam logic [3:0] S_SINE  = 4'd2;
  localparam logic [3:0] S_MUL_W = 4'd3;
  localparam logic [3:0] S_MUL_D = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_MUL_A = 4'd6;
  localparam logic [3:0] S_OMEGA = 4'd7;
  localparam logic [3:0] S_MUL_T = 4'd8;
  localparam logic [3:0] S_THETA = 4'd9;
  localparam logic [3:0] S_WRITE = 4'd10;

  logic [3:0]              state;
  logic signed [SW-1:0]    theta;
  logic signed [SW-1:0]    omega;
  dpi_pkg::op_t            cur;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    ws;
  logic signed [MAW-1:0]   a12;
  logic signed [15:0]      sine;

  logic signed [MAW-1:0]   ma;
  logic signed [MBW-1:0]   mb;
  logic signed [PW-1:0]    mprod;
  logic signed [SW:0]      theta_wide;
  logic signed [SW:0]      theta_abs;
  logic [15:0]             phase;
  logic [IXW-1:0]          idx_prod;
  logic [TIW-1:0]          idx;
  logic [TIW-1:0]          idx_sel;
  logic [SVW-1:0]          sine_mag;
  logic signed [15:0]      sine_next;
  logic signed [PW-1:0]    a26;
  logic signed [PW-1:0]    a12_full;
  logic signed [PW-1:0]    theta_ext;
  logic signed [PW-1:0]    omega_ext;
  logic                    out_free;

  assign pop      = (state == S_IDLE) && !queue_empty;
  assign out_free = !out_valid || out_ready;

  // operand select for the shared multiplier
  always_comb begin
    theta_wide = (SW+1)'(theta);
    theta_abs  = theta_wide[SW] ? -theta_wide : theta_wide;
    ma = '0;
    mb = '0;
    unique case (state)
      S_PHASE: begin
        ma = MAW'(theta_abs);
        mb = dpi_pkg::TURN_PER_RAD;
      end
      S_MUL_W: begin
        ma = MAW'(sine);
        mb = {2'b00, cfg.omega_sq};
      end
      S_MUL_D: begin
        ma = MAW'(omega);
        mb = {2'b00, cfg.damping_rate};
      end
      S_MUL_A: begin
        ma = a12;
        mb = {{(MBW-DTW){1'b0}}, cur.dt};
      end
      S_MUL_T: begin
        ma = MAW'(omega);
        mb = {{(MBW-DTW){1'b0}}, cur.dt};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod = ma * mb;
  end

  // quarter-wave lookup from the registered phase product
  always_comb begin
    phase    = prod[27:12];
    idx_prod = IXW'(phase[13:0]) * IXW'(dpi_pkg::SINE_TABLE_ENTRIES);
    idx      = idx_prod[IXW-1:14];
    idx_sel  = phase[14] ? (TIW'(dpi_pkg::SINE_TABLE_ENTRIES) - idx) : idx;
    sine_mag = dpi_pkg::SINE_TABLE[idx_sel];
    if (phase[15] ^ theta[SW-1]) begin
      sine_next = -$signed({1'b0, sine_mag});
    end else begin
      sine_next = $signed({1'b0, sine_mag});
    end
  end

  always_comb begin
    a26       = -ws - (prod <<< 2);
    a12_full  = (a26 + RND14) >>> 14;
    theta_ext = PW'(theta);
    omega_ext = PW'(omega);
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      theta     <= dpi_pkg::clamp_in($signed(dpi_pkg::START_ANGLE_RESET));
      omega     <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_WRITE sets or holds the result flag itself
      if (out_ready && state != S_WRITE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            if (op.load_theta) theta <= op.theta_val;
            if (op.zero_omega) omega <= '0;
            state <= op.do_step ? S_PHASE : S_WRITE;
          end
        end
        S_PHASE: state <= S_SINE;
        S_SINE:  state <= S_MUL_W;
        S_MUL_W: state <= S_MUL_D;
        S_MUL_D: state <= S_ACC;
        S_ACC:   state <= S_MUL_A;
        S_MUL_A: state <= S_OMEGA;
        S_OMEGA: begin
          omega <= dpi_pkg::sat_state(omega_ext + ((prod + RND16) >>> 16));
          state <= S_MUL_T;
        end
        S_MUL_T: state <= S_THETA;
        S_THETA: begin
          theta <= dpi_pkg::sat_state(theta_ext + ((prod + RND16) >>> 16));
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) cur <= op;
    unique case (state)
      S_PHASE, S_MUL_W, S_MUL_A, S_MUL_T: prod <= mprod;
      S_MUL_D: begin
        prod <= mprod;
        ws   <= prod;
      end
      S_SINE: sine <= sine_next;
      S_ACC:  a12  <= a12_full[MAW-1:0];
      S_WRITE: begin
        if (out_free) begin
          angle <= theta_ext[15:0];
          rate  <= omega_ext[15:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/damped_pendulum_integrator.sv */
// Top level of the damped pendulum integrator: configuration registers and block wiring.
`default_nettype none

// Damped pendulum integrator. Each input item is one tick and gives exactly one
// result item: the angle and angular rate (signed Q4.12) after the tick. Free,
// reset and release ticks take a semi-implicit Euler step; a drag tick loads
// drag_angle and zeroes the rate without stepping. A stepping tick walks the
// sequencer through every state, a drag tick only from idle to the write state;
// a step runs five dependent products (phase, w0^2*sin, damping*rate, accel*dt,
// rate*dt) through one shared registered multiplier, with a registered sine
// lookup in between. A two-entry op queue sits in front of the sequencer, so up
// to two ticks are taken while a step is running, and the result register lets
// the next step run while a result waits to be taken. Configuration writes take
// effect at once and are meant for an idle block only.
module damped_pendulum_integrator (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  // tick items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire logic [15:0]        elapsed_ms,
  input  wire logic signed [15:0] drag_angle,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      angle,
  output logic signed [15:0]      rate
);

  dpi_pkg::cfg_t cfg;
  dpi_pkg::op_t  front_op;
  dpi_pkg::op_t  queue_op;
  logic          push;
  logic          pop;
  logic          queue_full;
  logic          queue_empty;

  // configuration registers; all four indexes map to a register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.omega_sq     <= dpi_pkg::OMEGA_SQ_RESET;
      cfg.damping_rate <= dpi_pkg::DAMPING_RESET;
      cfg.start_angle  <= dpi_pkg::START_ANGLE_RESET;
      cfg.max_step_ms  <= dpi_pkg::MAX_STEP_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpi_pkg::REG_OMEGA_SQ:    cfg.omega_sq     <= cfg_data;
        dpi_pkg::REG_DAMPING:     cfg.damping_rate <= cfg_data;
        dpi_pkg::REG_START_ANGLE: cfg.start_angle  <= cfg_data;
        dpi_pkg::REG_MAX_STEP_MS: cfg.max_step_ms  <= cfg_data[7:0];
      endcase
    end
  end

  // clamp time, look up dt, decode command
  dpi_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .elapsed_ms (elapsed_ms),
    .drag_angle (drag_angle),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .op         (front_op)
  );

  dpi_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_op (front_op),
    .pop   (pop),
    .rd_op (queue_op),
    .full  (queue_full),
    .empty (queue_empty)
  );

  // owns theta and omega; one op at a time
  dpi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op          (queue_op),
    .queue_empty (queue_empty),
    .pop         (pop),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .angle       (angle),
    .rate        (rate)
  );

endmodule

`default_nettype wire

/* design/dpi_checker.sv */
// Port-level checks for the damped pendulum integrator, bound to the top level.
`default_nettype none

module dpi_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] angle,
  input wire logic signed [15:0] rate
);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 3'd1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(rate))
    else $error("stalled result changed");

  a_ready_falls_on_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_acc))
    else $error("input ready dropped without an accepted item");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without an accepted item");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more items in flight than the block can hold");

endmodule

bind damped_pendulum_integrator dpi_checker u_dpi_checker (.*);

`default_nettype wire

/* test/tb_damped_pendulum_integrator.sv */
// Testbench for the damped pendulum integrator: directed ticks, then random phases.

// Runs a short list of directed ticks, then random ticks over several register settings,
// with bursty input and a stalling receiver. Every tick is predicted by an in-bench copy
// of the pendulum arithmetic and compared field by field with the result item.
module tb_damped_pendulum_integrator;

  localparam int  PHASES      = 10;
  localparam int  PHASE_TICKS = 75;
  localparam int  HOLD_CYCLES = 300;
  localparam int  SINE_N      = dpi_pkg::SINE_TABLE_ENTRIES;
  localparam longint SAT_HI   = (longint'(1) <<< (dpi_pkg::STATE_WIDTH - 1)) - 1;
  localparam longint SAT_LO   = -(longint'(1) <<< (dpi_pkg::STATE_WIDTH - 1));
  localparam logic [63:0] HALF_PI_Q30_TB = 64'd1686629713;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] rate;
  } swing_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        ms;
    logic signed [15:0] drag;
    logic               fixed;   // expected result typed in below
    logic signed [15:0] angle;
    logic signed [15:0] rate;
  } tick_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         command;
  logic [15:0]        elapsed_ms;
  logic signed [15:0] drag_angle;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] angle;
  logic signed [15:0] rate;

  // hand-typed expectation riding along with the payload
  logic               tick_fixed;
  logic signed [15:0] tick_angle;
  logic signed [15:0] tick_rate;

  damped_pendulum_integrator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .elapsed_ms (elapsed_ms),
    .drag_angle (drag_angle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle      (angle),
    .rate       (rate)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pendulum predictor: register shadows, state, quarter-wave sine
  // ---------------------------------------------------------------------------
  logic [15:0]        w0_sq_sh   = dpi_pkg::OMEGA_SQ_RESET;
  logic [15:0]        damp_sh    = dpi_pkg::DAMPING_RESET;
  logic signed [15:0] home_sh    = dpi_pkg::START_ANGLE_RESET;
  logic [7:0]         max_ms_sh  = dpi_pkg::MAX_STEP_MS_RESET;
  longint             pend_theta = 3217;
  longint             pend_omega = 0;
  longint             sine_q14 [0:SINE_N];

  swing_t swing_q [$];

  int errors      = 0;
  int items_sent  = 0;
  int results_got = 0;
  int hold_asked  = 0;
  int hold_served = 0;

  function automatic void fill_sine();
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    for (int i = 0; i <= SINE_N; i++) begin
      x    = (HALF_PI_Q30_TB * 64'(i)) / 64'(SINE_N);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      sine_q14[i] = longint'(r);
    end
  endfunction

  function automatic longint clamp_state(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint sine_at(longint a);
    logic        neg;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] quad;
    logic [63:0] idx;
    longint      s;
    neg  = (a < 0);
    m    = neg ? 64'(-a) : 64'(a);
    p    = ((m * 64'd10430) >> 12) & 64'hFFFF;
    quad = p >> 14;
    idx  = ((p & 64'h3FFF) * 64'(SINE_N)) >> 14;
    if (idx > 64'(SINE_N)) idx = 64'(SINE_N);
    if (quad[0]) idx = 64'(SINE_N) - idx;
    s = sine_q14[idx];
    if (quad[1]) s = -s;
    return neg ? -s : s;
  endfunction

  // one semi-implicit Euler step: rate first, then angle with the new rate
  function automatic void euler_step(logic [15:0] ms_in);
    longint ms;
    longint dt;
    longint a26;
    longint a12;
    ms  = (ms_in < 16'(max_ms_sh)) ? longint'(ms_in) : longint'(max_ms_sh);
    dt  = (ms * 65536) / 1000;
    a26 = -longint'(w0_sq_sh) * sine_at(pend_theta) - 4 * longint'(damp_sh) * pend_omega;
    a12 = (a26 + 8192) >>> 14;
    pend_omega = clamp_state(pend_omega + ((a12 * dt + 32768) >>> 16));
    pend_theta = clamp_state(pend_theta + ((pend_omega * dt + 32768) >>> 16));
  endfunction

  function automatic swing_t swing_tick(logic [1:0] cmd, logic [15:0] ms,
                                        logic signed [15:0] drag);
    swing_t s;
    case (cmd)
      dpi_pkg::CMD_RESET: begin
        pend_theta = clamp_state(longint'(home_sh));
        pend_omega = 0;
        euler_step(ms);
      end
      dpi_pkg::CMD_DRAG: begin
        // held by hand: no step, elapsed time ignored
        pend_theta = clamp_state(longint'(drag));
        pend_omega = 0;
      end
      dpi_pkg::CMD_RELEASE: begin
        pend_omega = 0;
        euler_step(ms);
      end
      default: euler_step(ms);
    endcase
    s.angle = pend_theta[15:0];
    s.rate  = pend_omega[15:0];
    return s;
  endfunction

  initial fill_sine();

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted tick, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    swing_t exp_s;
    swing_t pred;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred = swing_tick(command, elapsed_ms, drag_angle);
        if (tick_fixed) begin
          pred.angle = tick_angle;
          pred.rate  = tick_rate;
        end
        swing_q.push_back(pred);
      end
      if (out_valid && out_ready) begin
        results_got++;
        if (swing_q.size() == 0) begin
          $error("result with nothing expected: angle %0d rate %0d", angle, rate);
          errors++;
        end else begin
          exp_s = swing_q.pop_front();
          if (angle !== exp_s.angle) begin
            $error("angle mismatch: expected %0d, got %0d", exp_s.angle, angle);
            errors++;
          end
          if (rate !== exp_s.rate) begin
            $error("rate mismatch: expected %0d, got %0d", exp_s.rate, rate);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: randomly chosen stall patterns, plus a long hold-off whenever the
  // sender asks for one
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    int       rx_cycle;
    out_ready = 1'b0;
    rx_mode   = RX_OPEN;
    mode_left = 0;
    rx_cycle  = 0;
    forever begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        // hold off long enough for the op queue and result register to fill
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      rx_cycle++;
      @(negedge clk);
      case (rx_mode)
        RX_OPEN:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= $urandom_range(0, 1);
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= (rx_cycle % 3 != 0);
      endcase
    end
  end

  // overall limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb_damped_pendulum_integrator NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // offer one tick; in_valid stays up across back-to-back items
  task automatic offer_tick(input logic [1:0] cmd, input logic [15:0] ms,
                            input logic signed [15:0] drag, input logic fixed,
                            input logic signed [15:0] ea, input logic signed [15:0] er);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= cmd;
    elapsed_ms <= ms;
    drag_angle <= drag;
    tick_fixed <= fixed;
    tick_angle <= ea;
    tick_rate  <= er;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic random_tick();
    logic [1:0]         cmd;
    logic [15:0]        ms;
    logic signed [15:0] drag;
    int                 pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) cmd = dpi_pkg::CMD_FREE;
    else if (pick < 14) cmd = dpi_pkg::CMD_RESET;
    else if (pick < 17) cmd = dpi_pkg::CMD_DRAG;
    else cmd = dpi_pkg::CMD_RELEASE;
    case ($urandom_range(0, 9))
      0:       ms = 16'($urandom);
      1:       ms = 16'd0;
      2:       ms = 16'hFFFF;
      default: ms = 16'($urandom_range(0, 300));
    endcase
    if ($urandom_range(0, 1) == 0) drag = 16'($urandom);
    else drag = 16'($signed($urandom_range(0, 12868)) - 6434);
    offer_tick(cmd, ms, drag, 1'b0, 16'sd0, 16'sd0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (swing_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      dpi_pkg::REG_OMEGA_SQ:    w0_sq_sh  = data;
      dpi_pkg::REG_DAMPING:     damp_sh   = data;
      dpi_pkg::REG_START_ANGLE: home_sh   = data;
      default:                  max_ms_sh = data[7:0];   // upper byte is dropped
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_all(input logic [15:0] w0, input logic [15:0] damp,
                         input logic [15:0] home, input logic [15:0] max_ms);
    cfg_write(dpi_pkg::REG_OMEGA_SQ, w0);
    cfg_write(dpi_pkg::REG_DAMPING, damp);
    cfg_write(dpi_pkg::REG_START_ANGLE, home);
    cfg_write(dpi_pkg::REG_MAX_STEP_MS, max_ms);
  endtask

  // directed ticks under the reset settings (max_step_ms 50)
  tick_row_t dir_rows [0:23] = '{
    // untouched after reset, zero time leaves the home angle
    '{dpi_pkg::CMD_FREE,    16'd0,     16'sd0,     1'b1, 16'sd3217,  16'sd0},
    '{dpi_pkg::CMD_DRAG,    16'd1234,  16'sd0,     1'b1, 16'sd0,     16'sd0},
    // resting at the bottom stays there
    '{dpi_pkg::CMD_FREE,    16'd1000,  16'sd0,     1'b1, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_DRAG,    16'd0,     16'sd32767, 1'b1, 16'sd32767, 16'sd0},
    '{dpi_pkg::CMD_FREE,    16'hFFFF,  16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd50,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_RELEASE, 16'd0,     16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_DRAG,    16'hFFFF,  16'h8000,   1'b1, 16'h8000,   16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd49,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd51,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_RELEASE, 16'd30,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_RESET,   16'd0,     16'sd0,     1'b1, 16'sd3217,  16'sd0},
    '{dpi_pkg::CMD_RESET,   16'd50,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd1,     16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_DRAG,    16'd0,     16'hFFFF,   1'b1, 16'hFFFF,   16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd255,   16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_RELEASE, 16'hFFFF,  16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_DRAG,    16'd0,     16'sd6434,  1'b1, 16'sd6434,  16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd20,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd20,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_DRAG,    16'd7,     -16'sd6434, 1'b1, -16'sd6434, 16'sd0},
    '{dpi_pkg::CMD_FREE,    16'd10,    16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_RESET,   16'd7,     16'sd0,     1'b0, 16'sd0,     16'sd0},
    '{dpi_pkg::CMD_RELEASE, 16'd0,     16'sd0,     1'b0, 16'sd0,     16'sd0}
  };

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = dpi_pkg::REG_OMEGA_SQ;
    cfg_data   = 16'd0;
    in_valid   = 1'b0;
    command    = dpi_pkg::CMD_FREE;
    elapsed_ms = 16'd0;
    drag_angle = 16'sd0;
    tick_fixed = 1'b0;
    tick_angle = 16'sd0;
    tick_rate  = 16'sd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset settings
    foreach (dir_rows[i])
      offer_tick(dir_rows[i].cmd, dir_rows[i].ms, dir_rows[i].drag,
                 dir_rows[i].fixed, dir_rows[i].angle, dir_rows[i].rate);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      // settings change only with the block idle
      case (ph)
        0: ;                                                    // reset settings
        2: cfg_all(16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF);     // top of every range, most negative start angle
        3: cfg_all(16'd0, 16'd0, 16'h7FFF, 16'd0);              // zero time, no forces
        5: cfg_all(16'hFFFF, 16'd0, 16'($urandom), 16'd255);    // undamped, drives saturation
        default: cfg_all(16'($urandom), 16'($urandom_range(0, 4096)), 16'($urandom),
                         16'($urandom_range(0, 255)) | (16'($urandom) & 16'hFF00));
      endcase
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // long receiver hold-off while ticks keep coming
        if (ph == 2 && n == 10) hold_asked++;
        // sender stops until every result is back
        if (ph == 4 && n == 40) wait_drained();
        random_tick();
      end
      wait_drained();
    end

    // late results would still be caught by the monitor
    repeat (40) @(posedge clk);
    $display("%0d ticks sent over %0d register settings, %0d results checked",
             items_sent, PHASES, results_got);
    $display("covered: all commands, clamped and zero time, saturation, long hold-off");
    if (errors == 0 && swing_q.size() == 0) begin
      $display("tb_damped_pendulum_integrator OK");
    end else begin
      if (swing_q.size() != 0) $error("%0d expected results never came", swing_q.size());
      $display("tb_damped_pendulum_integrator NOT OK");
    end
    $finish;
  end

endmodule
